>>> src/pde_pkg.sv
// shared constants, codes and types for the pointer deque engine
package pde_pkg;

    // ring geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // port field widths
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ICOUNT_W = 7;

    // operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_PEEK       = 3'd4,
        OP_POKE       = 3'd5
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // request to the slot memory
    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] wdata;
    } t_mem_req;

    // result of one operation, apart from the word read
    typedef struct packed {
        logic             is_read;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

>>> src/pointer_deque_engine.sv
// top level of the pointer deque engine: handshakes, slot ram and result register
//
//  channel   dir  handshake                      word
//  s_axis    in   s_axis_tvalid / s_axis_tready  opcode, index, value
//  m_axis    out  m_axis_tvalid / m_axis_tready  read_value, item_count, status
//
//  one word a cycle; a result appears the cycle after its word is accepted,
//  set by the single read-first port of the slot ram (at most one access per word)
//  a new word is taken while the result register is empty or being drained
//  reset (synchronous, active low) clears the pointers and the result valid;
//  the slot ram is not cleared, no slot is read before it is written
module pointer_deque_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // index[5:0], value[37:6], zero[39:38]
    input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // read_value[31:0], item_count[38:32], zero[39]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import pde_pkg::*;

    logic                  accept;
    t_mem_req              mem_req;
    t_result               result;
    t_result               r_result;
    logic                  r_valid;
    logic [DATA_WIDTH-1:0] rdata;
    logic [63:0]           rdata_wide;
    logic [31:0]           count_wide;
    logic [31:0]           read_value;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // pointer control
    pde_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_opcode  (s_axis_tuser),
        .i_index   (s_axis_tdata[5:0]),
        .i_value   (s_axis_tdata[37:6]),
        .o_mem_req (mem_req),
        .o_result  (result)
    );

    // slot storage
    pde_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_en    (mem_req.en),
        .i_we    (mem_req.we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (rdata)
    );

    // result register, ram output holds while the result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    // output word assembly
    assign rdata_wide = 64'(rdata);
    assign read_value = r_result.is_read ? rdata_wide[31:0] : 32'd0;
    assign count_wide = 32'(r_result.count);

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {1'b0, count_wide[ICOUNT_W-1:0], read_value};
    assign m_axis_tuser  = r_result.status;

endmodule

>>> src/pde_ram.sv
// generic single-port synchronous ram with registered read-first output
module pde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when the same slot is written
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pde_ctrl.sv
// pointer and count keeping, slot address generation and status decode
module pde_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [2:0]              i_opcode,
    input  logic [5:0]              i_index,
    input  logic [31:0]             i_value,
    output pde_pkg::t_mem_req       o_mem_req,
    output pde_pkg::t_result        o_result
);
    import pde_pkg::*;

    localparam int SUM_W = ADDR_W + 8;

    logic [ADDR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              full;
    logic              empty;
    logic              in_range;
    logic [63:0]       value_wide;
    logic [ADDR_W-1:0] front_dec;
    logic [ADDR_W-1:0] front_inc;
    logic [ADDR_W-1:0] addr_back;
    logic [ADDR_W-1:0] addr_last;
    logic [ADDR_W-1:0] addr_index;

    // logical to physical slot, sum stays below twice the depth when used
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] front,
                                               input logic [SUM_W-1:0]  offset);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] wrapped;
        sum     = SUM_W'(front) + offset;
        wrapped = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
        return wrapped[ADDR_W-1:0];
    endfunction

    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);
    assign in_range   = (32'(i_index) < 32'(r_count));
    assign value_wide = 64'(i_value);
    assign front_dec  = (r_front == '0) ? ADDR_W'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc  = (r_front == ADDR_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign addr_back  = phys(r_front, SUM_W'(r_count));
    assign addr_last  = phys(r_front, SUM_W'(r_count - 1'b1));
    assign addr_index = phys(r_front, SUM_W'(i_index));

    // decode of one operation
    always_comb begin
        n_front           = r_front;
        n_count           = r_count;
        o_mem_req.en      = 1'b0;
        o_mem_req.we      = 1'b0;
        o_mem_req.addr    = addr_index;
        o_mem_req.wdata   = value_wide[DATA_WIDTH-1:0];
        o_result.is_read  = 1'b0;
        o_result.status   = ST_OK;
        case (i_opcode)
            OP_PUSH_BACK: begin
                if (full) begin
                    o_result.status = ST_FULL;
                end else begin
                    o_mem_req.en   = i_accept;
                    o_mem_req.we   = 1'b1;
                    o_mem_req.addr = addr_back;
                    n_count        = r_count + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    o_result.status = ST_FULL;
                end else begin
                    o_mem_req.en   = i_accept;
                    o_mem_req.we   = 1'b1;
                    o_mem_req.addr = front_dec;
                    n_front        = front_dec;
                    n_count        = r_count + 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    o_result.status = ST_RANGE;
                end else begin
                    o_mem_req.en     = i_accept;
                    o_mem_req.addr   = addr_last;
                    o_result.is_read = 1'b1;
                    n_count          = r_count - 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    o_result.status = ST_RANGE;
                end else begin
                    o_mem_req.en     = i_accept;
                    o_mem_req.addr   = r_front;
                    o_result.is_read = 1'b1;
                    n_front          = front_inc;
                    n_count          = r_count - 1'b1;
                end
            end
            OP_PEEK: begin
                if (!in_range) begin
                    o_result.status = ST_RANGE;
                end else begin
                    o_mem_req.en     = i_accept;
                    o_result.is_read = 1'b1;
                end
            end
            OP_POKE: begin
                if (!in_range) begin
                    o_result.status = ST_RANGE;
                end else begin
                    o_mem_req.en     = i_accept;
                    o_mem_req.we     = 1'b1;
                    o_result.is_read = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_result.count = n_count;
    end

    // pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

endmodule

>>> bench/tb_pointer_deque_engine.sv
// self-checking bench for the pointer deque engine: predicted deque state against the result stream
module tb_pointer_deque_engine;
    import pde_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;

    // opcodes the block treats as no operation
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    // flavours of random traffic
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ACCESS, MIX_NOISE} t_mix;

    // one expected result word
    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [ICOUNT_W-1:0] item_count;
    } t_answer;

    // tracks the deque contents and the answers still owed by the block
    class deque_ledger;
        logic [VALUE_W-1:0] slot_mem [DEPTH];
        int unsigned        front;
        int unsigned        held;
        t_answer            owed[$];
        int                 errors;

        function new();
            front  = 0;
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // apply one accepted word to the tracked deque and queue its answer
        function void note_word(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                                logic [VALUE_W-1:0] val);
            t_answer     ans;
            int unsigned pos;
            ans.read_value = '0;
            ans.status     = ST_OK;
            case (op)
                OP_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        ans.status = ST_FULL;
                    end else begin
                        slot_mem[(front + held) % DEPTH] = val;
                        held++;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        ans.status = ST_FULL;
                    end else begin
                        front = (front + DEPTH - 1) % DEPTH;
                        slot_mem[front] = val;
                        held++;
                    end
                end
                OP_POP_BACK: begin
                    if (held == 0) begin
                        ans.status = ST_RANGE;
                    end else begin
                        held--;
                        ans.read_value = slot_mem[(front + held) % DEPTH];
                    end
                end
                OP_POP_FRONT: begin
                    if (held == 0) begin
                        ans.status = ST_RANGE;
                    end else begin
                        ans.read_value = slot_mem[front];
                        front = (front + 1) % DEPTH;
                        held--;
                    end
                end
                OP_PEEK: begin
                    if (idx >= held) begin
                        ans.status = ST_RANGE;
                    end else begin
                        ans.read_value = slot_mem[(front + idx) % DEPTH];
                    end
                end
                OP_POKE: begin
                    if (idx >= held) begin
                        ans.status = ST_RANGE;
                    end else begin
                        pos = (front + idx) % DEPTH;
                        ans.read_value = slot_mem[pos];
                        slot_mem[pos] = val;
                    end
                end
                default: begin
                end
            endcase
            ans.item_count = ICOUNT_W'(held);
            owed.push_back(ans);
        endfunction

        // one line per mismatch, quiet once the log is long enough
        task report(string what, logic [39:0] got, logic [39:0] want);
            if (errors < 50)
                $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endtask

        // compare a delivered result with the oldest answer owed
        task check_answer(logic [VALUE_W-1:0] rd, logic [STATUS_W-1:0] st,
                          logic [ICOUNT_W-1:0] cnt);
            t_answer ans;
            if (owed.size() == 0) begin
                report("unexpected result word", {rd, 1'b0, cnt}, '0);
            end else begin
                ans = owed.pop_front();
                if (rd !== ans.read_value)
                    report("read_value", 40'(rd), 40'(ans.read_value));
                if (st !== ans.status)
                    report("status", 40'(st), 40'(ans.status));
                if (cnt !== ans.item_count)
                    report("item_count", 40'(cnt), 40'(ans.item_count));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;  // index[5:0], value[37:6], zero[39:38]
    logic [2:0]  s_axis_tuser;  // opcode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;  // read_value[31:0], item_count[38:32], zero[39]
    logic [1:0]  m_axis_tuser;  // status[1:0]

    deque_ledger ledger;
    bit          idle_on = 1'b1;
    bit          hold_request = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    pointer_deque_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // offer one word, with an optional idle burst first; returns at the accepting edge
    task automatic send_word(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                             logic [VALUE_W-1:0] val);
        bit taken;
        taken = 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, val, idx};
        s_axis_tvalid <= 1'b1;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            if (taken) ledger.note_word(op, idx, val);
            @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every owed answer has come back
    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall bursts, plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result words are checked at the falling edge before the edge that takes them
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid && m_axis_tready && ledger != null)
            ledger.check_answer(m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[38:32]);
    end

    // run limit
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pointer_deque_engine test failed");
        $finish;
    end

    // stimulus
    initial begin
        int                  sent;
        int                  len;
        int                  r;
        t_mix                mix;
        bit                  hold_done;
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  val;

        ledger        = new();
        hold_done     = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: pops, peek and poke refused; spare opcodes do nothing
        send_word(OP_POP_BACK, 6'd0, 32'h0);
        send_word(OP_POP_FRONT, 6'd63, 32'hFFFF_FFFF);
        send_word(OP_PEEK, 6'd0, 32'h0);
        send_word(OP_POKE, 6'd63, 32'hFFFF_FFFF);
        send_word(OP_SPARE_LO, 6'd0, 32'h0);
        send_word(OP_SPARE_HI, 6'd63, 32'hFFFF_FFFF);
        // fill from both ends, then read and rewrite by position
        send_word(OP_PUSH_BACK, 6'd63, 32'hFFFF_FFFF);
        send_word(OP_PUSH_FRONT, 6'd0, 32'h0);
        send_word(OP_PUSH_BACK, 6'd0, 32'hA5A5_A5A5);
        send_word(OP_PEEK, 6'd0, 32'hFFFF_FFFF);
        send_word(OP_PEEK, 6'd2, 32'h0);
        send_word(OP_PEEK, 6'd3, 32'h0);
        send_word(OP_PEEK, 6'd63, 32'h0);
        send_word(OP_POKE, 6'd1, 32'h5A5A_5A5A);
        send_word(OP_POKE, 6'd2, 32'h0);
        send_word(OP_POKE, 6'd3, 32'h1234_5678);
        send_word(OP_SPARE_HI, 6'd1, 32'hDEAD_BEEF);
        // empty it again from both ends and pop once more
        send_word(OP_POP_FRONT, 6'd0, 32'h0);
        send_word(OP_POP_BACK, 6'd0, 32'h0);
        send_word(OP_POP_BACK, 6'd0, 32'h0);
        send_word(OP_POP_FRONT, 6'd0, 32'h0);
        drain_answers();

        // random traffic in phases
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            idle_on = (sent < RANDOM_WORDS - 100) && ($urandom_range(0, 3) != 0);
            if (!hold_done && sent >= 100) begin
                // output held back as a run of pushes past full begins, then pops drain past empty
                hold_done    = 1'b1;
                hold_request = 1'b1;
                repeat (DEPTH + 6) begin
                    op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                    send_word(op, 6'($urandom), $urandom);
                    sent++;
                end
                drain_answers();
                repeat (DEPTH + 6) begin
                    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                    send_word(op, 6'($urandom), $urandom);
                    sent++;
                end
            end else begin
                mix = t_mix'($urandom_range(0, 3));
                len = (mix == MIX_FILL) ? $urandom_range(20, 120) : $urandom_range(10, 60);
                if (len > RANDOM_WORDS - sent) len = RANDOM_WORDS - sent;
                repeat (len) begin
                    // no idling in the last stretch of the run
                    if (sent >= RANDOM_WORDS - 100) idle_on = 1'b0;
                    r   = $urandom_range(0, 99);
                    val = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
                    idx = (ledger.held > 0 && $urandom_range(0, 3) != 0) ?
                          6'($urandom_range(0, ledger.held - 1)) : 6'($urandom);
                    case (mix)
                        MIX_FILL: begin
                            if (r < 75)      op = $urandom_range(0, 1) ? OP_PUSH_FRONT
                                                                       : OP_PUSH_BACK;
                            else if (r < 85) op = $urandom_range(0, 1) ? OP_POP_FRONT
                                                                       : OP_POP_BACK;
                            else             op = $urandom_range(0, 1) ? OP_POKE : OP_PEEK;
                        end
                        MIX_DRAIN: begin
                            if (r < 70)      op = $urandom_range(0, 1) ? OP_POP_FRONT
                                                                       : OP_POP_BACK;
                            else if (r < 80) op = $urandom_range(0, 1) ? OP_PUSH_FRONT
                                                                       : OP_PUSH_BACK;
                            else             op = $urandom_range(0, 1) ? OP_POKE : OP_PEEK;
                        end
                        MIX_ACCESS: begin
                            if (r < 60)      op = $urandom_range(0, 1) ? OP_POKE : OP_PEEK;
                            else if (r < 80) op = $urandom_range(0, 1) ? OP_PUSH_FRONT
                                                                       : OP_PUSH_BACK;
                            else if (r < 95) op = $urandom_range(0, 1) ? OP_POP_FRONT
                                                                       : OP_POP_BACK;
                            else             op = $urandom_range(0, 1) ? OP_SPARE_HI
                                                                       : OP_SPARE_LO;
                        end
                        default: begin
                            op  = 3'($urandom);
                            idx = 6'($urandom);
                        end
                    endcase
                    send_word(op, idx, val);
                    sent++;
                end
                if ($urandom_range(0, 5) == 0) drain_answers();
            end
        end

        // wait for the last answers, then idle until the settle time is over
        drain_answers();
        repeat (SETTLE) @(posedge i_clk);
        while (ledger.pending() != 0) begin
            ledger.report("answer never delivered", '0, '0);
            void'(ledger.owed.pop_front());
        end
        if (ledger.errors == 0)
            $display("pointer_deque_engine test passed");
        else
            $display("pointer_deque_engine test failed");
        $finish;
    end

endmodule
